/* rtl/assert_macros.svh */
// assertion helper macros for the first-fit allocator rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
// shared types and constants for the first-fit heap allocator
// no dependencies
package ffha_pkg;

  // default sizing of the block table and block header
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;

  // heap limit handling
  localparam logic [24:0] LIMIT_CAP      = 25'h1000000;
  localparam logic [24:0] HEAP_LIMIT_RST = 25'd65536;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_REUSED       = 3'd0,
    ST_EXTENDED     = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_BAD_SIZE     = 3'd3,
    ST_FREED        = 3'd4,
    ST_FREE_IGNORED = 3'd5
  } ffha_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_END,
    S_RESP
  } ffha_state_t;

  // input word
  typedef struct packed {
    logic        req_type;
    logic [23:0] alloc_size;
    logic [31:0] free_addr;
  } ffha_req_t;

  // result word
  typedef struct packed {
    logic [31:0]  result_addr;
    ffha_status_t status;
  } ffha_rsp_t;

  // one block table entry
  typedef struct packed {
    logic [23:0] blk_off;
    logic [23:0] blk_size;
    logic        is_free;
  } ffha_entry_t;

endpackage

/* rtl/first_fit_heap_allocator_unit.sv */
// first-fit heap allocator top level: block table memory and scan sequencer
// depends on ffha_pkg and assert_macros.svh
//
// usage: in_word carries one allocate or free request, out_word one result
// (granted payload address and status). both channels move a word at an
// edge where valid is high and stall is low. cfg_we/cfg_index/cfg_data write
// heap_base (index 0) and heap_limit (index 1); write them only when idle.
// the block table sits in one synchronous memory read one entry per cycle.
// an allocate or free scans entries 0..block_count-1 in order and stops at
// the first hit; with no hit, an allocate appends a new block if there is
// space. a zero-size allocate or a null free skips the scan and goes
// straight to its result. one request is in work at a time; the
// next word is taken while a finished result still sits in the output
// register. if the receiver stalls, the result holds in out_word and the
// following result waits in the sequencer until the register frees up.
// reset empties the table (block count and heap top to zero), sets
// heap_base to 0 and heap_limit to 65536; table contents are not cleared.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ffha_req_t   in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output ffha_rsp_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [25:0] HDR26 = 26'(HEADER_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

  // control state
  ffha_state_t   state_r, state_nxt;
  logic [CW-1:0] blk_count_r, blk_count_nxt;
  logic [24:0]   heap_top_r, heap_top_nxt;
  logic [31:0]   heap_base_r;
  logic [24:0]   heap_limit_r;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rdv_r, rdv_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload state
  ffha_req_t     req_r, req_nxt;
  logic [31:0]   target_r, target_nxt;
  logic [IW-1:0] data_idx_r, data_idx_nxt;
  ffha_rsp_t     rsp_r, rsp_nxt;
  ffha_rsp_t     out_word_r, out_word_nxt;

  // block table memory
  ffha_entry_t   mem [0:MAX_BLOCKS-1];
  ffha_entry_t   rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  ffha_entry_t   mem_wdata;

  // scan and append helpers
  logic          issue;
  logic          hit;
  logic [24:0]   limit_eff;
  logic [25:0]   ext_sum;
  logic          no_space;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign rd_addr   = rd_idx_r[IW-1:0];

  assign limit_eff = (heap_limit_r > LIMIT_CAP) ? LIMIT_CAP : heap_limit_r;
  assign ext_sum   = {1'b0, heap_top_r} + HDR26 + {2'b0, req_r.alloc_size};
  assign no_space  = (blk_count_r >= MAX_CNT) || (ext_sum > {1'b0, limit_eff});
  assign issue     = (rd_idx_r < blk_count_r);

  // entry test: fitting free block for allocate, address match for free
  always_comb begin
    if (req_r.req_type == REQ_ALLOC) begin
      hit = rd_data_r.is_free && (rd_data_r.blk_size >= req_r.alloc_size);
    end else begin
      hit = ({8'b0, rd_data_r.blk_off} == target_r);
    end
  end

  // sequencer: next state, table writes and result
  always_comb begin
    state_nxt     = state_r;
    blk_count_nxt = blk_count_r;
    heap_top_nxt  = heap_top_r;
    rd_idx_nxt    = rd_idx_r;
    rdv_nxt       = rdv_r;
    req_nxt       = req_r;
    target_nxt    = target_r;
    data_idx_nxt  = data_idx_r;
    rsp_nxt       = rsp_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = data_idx_r;
    mem_wdata     = rd_data_r;

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_word;
          target_nxt = in_word.free_addr - heap_base_r - HDR32;
          rd_idx_nxt = '0;
          rdv_nxt    = 1'b0;
          if (in_word.req_type == REQ_ALLOC && in_word.alloc_size == 24'd0) begin
            rsp_nxt   = '{result_addr: 32'd0, status: ST_BAD_SIZE};
            state_nxt = S_RESP;
          end else if (in_word.req_type == REQ_FREE && in_word.free_addr == 32'd0) begin
            rsp_nxt   = '{result_addr: 32'd0, status: ST_FREE_IGNORED};
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rdv_r && hit) begin
          // update the free flag of the hit entry; read-ahead data is dropped
          mem_we            = 1'b1;
          mem_wdata.is_free = (req_r.req_type == REQ_FREE);
          rdv_nxt           = 1'b0;
          if (req_r.req_type == REQ_ALLOC) begin
            rsp_nxt = '{result_addr: heap_base_r + {8'b0, rd_data_r.blk_off} + HDR32,
                        status: ST_REUSED};
          end else begin
            rsp_nxt = '{result_addr: 32'd0, status: ST_FREED};
          end
          state_nxt = S_RESP;
        end else begin
          rdv_nxt      = issue;
          data_idx_nxt = rd_idx_r[IW-1:0];
          if (issue) begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
          if (!issue && !rdv_r) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        // table exhausted without a hit
        if (req_r.req_type == REQ_FREE) begin
          rsp_nxt = '{result_addr: 32'd0, status: ST_FREE_IGNORED};
        end else if (no_space) begin
          rsp_nxt = '{result_addr: 32'd0, status: ST_NO_SPACE};
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = blk_count_r[IW-1:0];
          mem_wdata     = '{blk_off: heap_top_r[23:0], blk_size: req_r.alloc_size,
                            is_free: 1'b0};
          blk_count_nxt = blk_count_r + 1'b1;
          heap_top_nxt  = ext_sum[24:0];
          rsp_nxt       = '{result_addr: heap_base_r + {8'b0, heap_top_r[23:0]} + HDR32,
                            status: ST_EXTENDED};
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = rsp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      blk_count_r <= '0;
      heap_top_r  <= '0;
      rd_idx_r    <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_count_r <= blk_count_nxt;
      heap_top_r  <= heap_top_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= 32'd0;
      heap_limit_r <= HEAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  heap_base_r  <= cfg_data;
        CFG_HEAP_LIMIT: heap_limit_r <= cfg_data[24:0];
        default:        heap_base_r  <= heap_base_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    target_r   <= target_nxt;
    data_idx_r <= data_idx_nxt;
    rsp_r      <= rsp_nxt;
    out_word_r <= out_word_nxt;
  end

  // block table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // checks
  `FFHA_ASSERT(a_count_bound, blk_count_r <= MAX_CNT, "block count above table size")
  `FFHA_ASSERT(a_top_bound, heap_top_r <= LIMIT_CAP, "heap top above limit cap")
  `FFHA_ASSERT(a_rdv_scan, !rdv_r || state_r == S_SCAN, "read data pending outside scan")
  `FFHA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE, "accept left idle")

endmodule
